>>> rtl/ascon_aead_stream_cipher_top_defines.svh
// Assertion helpers for the RTL, included by the sequencer.
`ifndef ASCON_AEAD_STREAM_CIPHER_TOP_DEFINES_SVH
`define ASCON_AEAD_STREAM_CIPHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ASC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ascon_sc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ascon_sc_pkg;

   typedef logic [5:0]       step_type;
   typedef logic [3:0]       rc_type;
   typedef logic [63:0]      word_type;
   typedef logic [4:0][63:0] lane_arr_type;

   // Input function codes
   localparam logic [1:0] FUNC_DATA = 2'd0;
   localparam logic [1:0] FUNC_LAST = 2'd1;
   localparam logic [1:0] FUNC_END  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_TAG_HI = 2'd1;
   localparam logic [1:0] KIND_TAG_LO = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_KEY_HIGH   = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW    = 3'd1;
   localparam logic [2:0] CSR_NONCE_HIGH = 3'd2;
   localparam logic [2:0] CSR_NONCE_LOW  = 3'd3;
   localparam logic [2:0] CSR_INIT_VALUE = 3'd4;
   localparam logic [2:0] CSR_DIRECTION  = 3'd5;

   localparam word_type IV_RESET = 64'h8040_0c06_0000_0000;

   // Datapath operations selected by the control word
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROUND,
      OP_KEY34,
      OP_KEY12,
      OP_DATA,
      OP_EMIT3,
      OP_EMIT4
   } op_type;

   // Next-step selection
   typedef enum logic [2:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_DISPATCH,
      JC_FUNC2,
      JC_FUNC0
   } jump_type;

   typedef struct packed {
      op_type   op;
      rc_type   rc_idx;
      jump_type jc;
      step_type target;
      logic     set_msg;
      logic     clr_msg;
   } uword_type;

   // Program layout
   localparam step_type STEP_IDLE     = 6'd0;
   localparam step_type STEP_INIT     = 6'd1;
   localparam step_type STEP_INIT_XOR = 6'd14;
   localparam step_type STEP_DATA     = 6'd15;
   localparam step_type STEP_DATA_END = 6'd21;
   localparam step_type STEP_FIN      = 6'd22;
   localparam step_type STEP_FIN_XOR  = 6'd35;
   localparam step_type STEP_EMIT3    = 6'd36;
   localparam step_type STEP_LAST     = 6'd37;

   // Control store: one word per step.
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w = '{op: OP_NONE, rc_idx: '0, jc: JC_NEXT, target: STEP_IDLE,
            set_msg: 1'b0, clr_msg: 1'b0};
      if (s == STEP_IDLE) begin
         w.jc = JC_DISPATCH;
      end else if (s == STEP_INIT) begin
         w.op = OP_LOAD;
      end else if (s < STEP_INIT_XOR) begin
         w.op     = OP_ROUND;
         w.rc_idx = rc_type'(s - (STEP_INIT + 6'd1));
      end else if (s == STEP_INIT_XOR) begin
         w.op      = OP_KEY34;
         w.set_msg = 1'b1;
         w.jc      = JC_FUNC2;
         w.target  = STEP_FIN;
      end else if (s == STEP_DATA) begin
         w.op = OP_DATA;
      end else if (s <= STEP_DATA_END) begin
         // last six rounds of the schedule
         w.op     = OP_ROUND;
         w.rc_idx = rc_type'(s - (STEP_DATA - 6'd5));
         if (s == STEP_DATA_END) begin
            w.jc     = JC_FUNC0;
            w.target = STEP_IDLE;
         end
      end else if (s == STEP_FIN) begin
         w.op = OP_KEY12;
      end else if (s < STEP_FIN_XOR) begin
         w.op     = OP_ROUND;
         w.rc_idx = rc_type'(s - (STEP_FIN + 6'd1));
      end else if (s == STEP_FIN_XOR) begin
         w.op = OP_KEY34;
      end else if (s == STEP_EMIT3) begin
         w.op = OP_EMIT3;
      end else if (s == STEP_LAST) begin
         w.op      = OP_EMIT4;
         w.clr_msg = 1'b1;
         w.jc      = JC_ALWAYS;
         w.target  = STEP_IDLE;
      end else begin
         w.jc     = JC_ALWAYS;
         w.target = STEP_IDLE;
      end
      return w;
   endfunction

endpackage
`default_nettype wire

>>> rtl/ascon_sc_round.sv
`timescale 1ns / 1ps
`default_nettype none
module ascon_sc_round (
   input  ascon_sc_pkg::lane_arr_type lanes_i,
   input  ascon_sc_pkg::rc_type       rc_idx,
   output ascon_sc_pkg::lane_arr_type lanes_o
);
   import ascon_sc_pkg::*;

   function automatic word_type ror(input word_type v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   always_comb begin
      word_type x0, x1, x2, x3, x4;
      word_type n0, n1, n2, n3, n4;
      x0 = lanes_i[0];
      x1 = lanes_i[1];
      // round constant i is {15-i, i} as two nibbles
      x2 = lanes_i[2] ^ {56'd0, ~rc_idx, rc_idx};
      x3 = lanes_i[3];
      x4 = lanes_i[4];
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      n0 = x0 ^ (~x1 & x2);
      n1 = x1 ^ (~x2 & x3);
      n2 = x2 ^ (~x3 & x4);
      n3 = x3 ^ (~x4 & x0);
      n4 = x4 ^ (~x0 & x1);
      n1 = n1 ^ n0;
      n0 = n0 ^ n4;
      n3 = n3 ^ n2;
      n2 = ~n2;
      lanes_o[0] = n0 ^ ror(n0, 19) ^ ror(n0, 28);
      lanes_o[1] = n1 ^ ror(n1, 61) ^ ror(n1, 39);
      lanes_o[2] = n2 ^ ror(n2, 1) ^ ror(n2, 6);
      lanes_o[3] = n3 ^ ror(n3, 10) ^ ror(n3, 17);
      lanes_o[4] = n4 ^ ror(n4, 7) ^ ror(n4, 41);
   end

endmodule
`default_nettype wire

>>> rtl/ascon_sc_useq.sv
`timescale 1ns / 1ps
`default_nettype none
module ascon_sc_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              req_func,
   input  logic                    hold,
   output ascon_sc_pkg::uword_type uw
);
   import ascon_sc_pkg::*;

   `include "ascon_aead_stream_cipher_top_defines.svh"

   step_type   step_ff, step_in;
   logic       msg_ff, msg_in;
   logic [1:0] func_ff, func_in;

   assign uw = ucode(step_ff);

   always_comb begin
      step_in = step_ff;
      msg_in  = msg_ff;
      func_in = func_ff;
      if (!hold) begin
         if (uw.set_msg) msg_in = 1'b1;
         if (uw.clr_msg) msg_in = 1'b0;
         unique case (uw.jc)
            JC_NEXT:   step_in = step_ff + 6'd1;
            JC_ALWAYS: step_in = uw.target;
            JC_FUNC2:  step_in = (func_ff == FUNC_END)  ? uw.target : step_ff + 6'd1;
            JC_FUNC0:  step_in = (func_ff == FUNC_DATA) ? uw.target : step_ff + 6'd1;
            JC_DISPATCH: begin
               if (accept) begin
                  func_in = req_func;
                  if (req_func == FUNC_NONE) begin
                     step_in = STEP_IDLE;
                  end else if (!msg_ff) begin
                     step_in = STEP_INIT;
                  end else if (req_func == FUNC_END) begin
                     step_in = STEP_FIN;
                  end else begin
                     step_in = STEP_DATA;
                  end
               end
            end
            default: step_in = STEP_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         msg_ff  <= 1'b0;
         func_ff <= FUNC_DATA;
      end else begin
         step_ff <= step_in;
         msg_ff  <= msg_in;
         func_ff <= func_in;
      end
   end

   `ASC_ASSERT_NXT(a_hold_keeps_step, clock, reset, hold, $stable(step_ff), "step moved on hold")
   `ASC_ASSERT_IMP(a_close_open_msg, clock, reset, uw.clr_msg, msg_ff, "closing unopened message")
   `ASC_ASSERT_IMP(a_step_range, clock, reset, 1'b1, step_ff <= STEP_LAST, "step out of program")
   `ASC_ASSERT_IMP(a_accept_idle, clock, reset, accept, uw.jc == JC_DISPATCH, "beat taken while busy")

endmodule
`default_nettype wire

>>> rtl/ascon_aead_stream_cipher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ASCON-128 style authenticated cipher, 64-bit rate, no associated data.
// req_*: one beat per item; tuser = func (data, last data, end), tdata = word.
// rsp_*: one beat per result; tdata = data or tag word, tuser = kind,
// tlast marks the second tag word that closes a message.
// csr_*: key, nonce, IV and direction writes, one register per cycle.
// A microcoded sequencer steps through a 38-word control store; each active step
// drives a permutation round, a lane update or a tag beat on the shared datapath.
// Steps per item, from accept to ready again:
//   data word in an open message: accept, lane update, 6 rounds
//   first item of a message: load, 12 rounds, key mix come first
//   last word: key mix, 12 rounds, key mix, two tag beats follow
//   end without word in an open message: accept, then those finalization steps
// rsp_tvalid rises once the data step has registered the result (after the
// opening steps if the item opens a message); tag words follow the last key mix.
// Reset closes any open message, empties the result register, holds req_tready
// low and returns the registers to their defaults. A stalled receiver holds the
// sequencer only at a step that must emit a beat while the previous one still
// waits; otherwise the next item is taken while a result sits in the register.
module ascon_aead_stream_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [63:0] data_word
   input  logic [1:0]  req_tuser,    // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [63:0] data_out
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);
   import ascon_sc_pkg::*;

   // configuration registers
   word_type key_high_ff, key_low_ff, nonce_high_ff, nonce_low_ff, init_value_ff;
   logic     direction_ff;

   lane_arr_type lanes_ff, lanes_in, round_out;
   word_type     word_ff;

   logic         rsp_valid_ff;
   word_type     rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_kind_ff, rsp_kind_in;
   logic         rsp_last_ff, rsp_last_in;

   uword_type uw;
   logic      accept;
   logic      emit;
   logic      hold;
   word_type  data_res;

   assign req_tready = (uw.jc == JC_DISPATCH) && !reset;
   assign accept     = req_tvalid && req_tready;

   // emit steps wait while an older beat is still unclaimed
   assign emit = (uw.op == OP_DATA) || (uw.op == OP_EMIT3) || (uw.op == OP_EMIT4);
   assign hold = emit && rsp_valid_ff && !rsp_tready;

   assign data_res = word_ff ^ lanes_ff[0];

   ascon_sc_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_func (req_tuser),
      .hold     (hold),
      .uw       (uw)
   );

   ascon_sc_round u_round (
      .lanes_i (lanes_ff),
      .rc_idx  (uw.rc_idx),
      .lanes_o (round_out)
   );

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff   <= '0;
         key_low_ff    <= '0;
         nonce_high_ff <= '0;
         nonce_low_ff  <= '0;
         init_value_ff <= IV_RESET;
         direction_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            CSR_NONCE_HIGH: nonce_high_ff <= csr_wdata;
            CSR_NONCE_LOW:  nonce_low_ff  <= csr_wdata;
            CSR_INIT_VALUE: init_value_ff <= csr_wdata;
            CSR_DIRECTION:  direction_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // lane datapath, one operation per step
   always_comb begin
      lanes_in = lanes_ff;
      case (uw.op)
         OP_LOAD: begin
            lanes_in[0] = init_value_ff;
            lanes_in[1] = key_high_ff;
            lanes_in[2] = key_low_ff;
            lanes_in[3] = nonce_high_ff;
            lanes_in[4] = nonce_low_ff;
         end
         OP_ROUND: lanes_in = round_out;
         OP_KEY34: begin
            lanes_in[3] = lanes_ff[3] ^ key_high_ff;
            lanes_in[4] = lanes_ff[4] ^ key_low_ff;
         end
         OP_KEY12: begin
            lanes_in[1] = lanes_ff[1] ^ key_high_ff;
            lanes_in[2] = lanes_ff[2] ^ key_low_ff;
         end
         // lane 0 takes the ciphertext side of the word
         OP_DATA: lanes_in[0] = direction_ff ? word_ff : data_res;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (!hold) lanes_ff <= lanes_in;
      if (accept) word_ff <= req_tdata;
   end

   // result register
   always_comb begin
      rsp_data_in = data_res;
      rsp_kind_in = KIND_DATA;
      rsp_last_in = 1'b0;
      case (uw.op)
         OP_EMIT3: begin
            rsp_data_in = lanes_ff[3];
            rsp_kind_in = KIND_TAG_HI;
         end
         OP_EMIT4: begin
            rsp_data_in = lanes_ff[4];
            rsp_kind_in = KIND_TAG_LO;
            rsp_last_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && !hold) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && !hold) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

>>> tb/tb_ascon_aead_stream_cipher_top.sv
`timescale 1ns / 1ps
module tb_ascon_aead_stream_cipher_top;
   import ascon_sc_pkg::*;

   // One result beat as it leaves rsp: data or tag word, kind, end-of-message mark.
   typedef struct packed {
      logic [63:0] data;
      logic [1:0]  kind;
      logic        last;
   } cipher_beat_type;

   // One row of the directed plan: the item and the number of beats it must give.
   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] word;
      logic [1:0]  n_beats;
   } plan_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 250;
   localparam int PLAN_ROWS      = 20;
   localparam int PLAN_SPLIT     = 11;

   // Directed plan. The first rows run at the reset register values; the rest
   // run with every register at its top value and decrypt selected. The last
   // row of the first part leaves its message open across the register change.
   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      '{FUNC_NONE, 64'h0000_0000_0000_0000, 2'd0},  // ignored, no message open
      '{FUNC_END,  64'h0000_0000_0000_0000, 2'd2},  // tag of an empty message
      '{FUNC_DATA, 64'h0000_0000_0000_0000, 2'd1},
      '{FUNC_DATA, 64'hffff_ffff_ffff_ffff, 2'd1},
      '{FUNC_NONE, 64'hffff_ffff_ffff_ffff, 2'd0},  // ignored inside a message
      '{FUNC_DATA, 64'h5555_5555_5555_5555, 2'd1},
      '{FUNC_LAST, 64'haaaa_aaaa_aaaa_aaaa, 2'd3},
      '{FUNC_LAST, 64'h0000_0000_0000_0000, 2'd3},  // open and close in one item
      '{FUNC_DATA, 64'h8000_0000_0000_0001, 2'd1},
      '{FUNC_END,  64'h0000_0000_0000_0000, 2'd2},  // end after data, no word
      '{FUNC_DATA, 64'h0123_4567_89ab_cdef, 2'd1},  // left open on purpose
      '{FUNC_DATA, 64'hffff_ffff_ffff_ffff, 2'd1},  // new key/direction mid-message
      '{FUNC_LAST, 64'h0000_0000_0000_0000, 2'd3},
      '{FUNC_END,  64'hffff_ffff_ffff_ffff, 2'd2},
      '{FUNC_DATA, 64'hffff_ffff_ffff_ffff, 2'd1},
      '{FUNC_DATA, 64'h0000_0000_0000_0000, 2'd1},
      '{FUNC_NONE, 64'h0000_0000_0000_0000, 2'd0},
      '{FUNC_LAST, 64'hffff_ffff_ffff_ffff, 2'd3},
      '{FUNC_LAST, 64'h7fff_ffff_ffff_fffe, 2'd3},
      '{FUNC_END,  64'h0000_0000_0000_0000, 2'd2}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;    // [63:0] data_word
   logic [1:0]  req_tuser;    // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [63:0] data_out
   logic [1:0]  rsp_tuser;    // [1:0] kind
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   // Cipher state mirror: register shadow, five lanes, open-message flag.
   logic [63:0]     csr_shadow [0:5];
   logic [63:0]     cipher_lanes [0:4];
   logic            msg_open;
   cipher_beat_type pending_beats [$];

   int error_count;
   int items_sent;
   int beats_checked;
   int settings_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_left;
   int quiet_cycles;

   ascon_aead_stream_cipher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Cipher predictor
   // ---------------------------------------------------------------------

   function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   // One permutation round: constant add, S-box layer, linear diffusion.
   task automatic ascon_round(input logic [7:0] rc);
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] n0, n1, n2, n3, n4;
      x0 = cipher_lanes[0];
      x1 = cipher_lanes[1];
      x2 = cipher_lanes[2] ^ {56'd0, rc};
      x3 = cipher_lanes[3];
      x4 = cipher_lanes[4];
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      n0 = x0 ^ (~x1 & x2);
      n1 = x1 ^ (~x2 & x3);
      n2 = x2 ^ (~x3 & x4);
      n3 = x3 ^ (~x4 & x0);
      n4 = x4 ^ (~x0 & x1);
      n1 = n1 ^ n0;
      n0 = n0 ^ n4;
      n3 = n3 ^ n2;
      n2 = ~n2;
      cipher_lanes[0] = n0 ^ ror64(n0, 19) ^ ror64(n0, 28);
      cipher_lanes[1] = n1 ^ ror64(n1, 61) ^ ror64(n1, 39);
      cipher_lanes[2] = n2 ^ ror64(n2, 1) ^ ror64(n2, 6);
      cipher_lanes[3] = n3 ^ ror64(n3, 10) ^ ror64(n3, 17);
      cipher_lanes[4] = n4 ^ ror64(n4, 7) ^ ror64(n4, 41);
   endtask

   // Run the last `rounds` steps of the 12-round schedule; round r uses the
   // constant {15-r, r}, so 0xf0 first and 0x4b last.
   task automatic ascon_permute(input int rounds);
      logic [3:0] ri;
      for (int r = 12 - rounds; r < 12; r++) begin
         ri = r[3:0];
         ascon_round({~ri, ri});
      end
   endtask

   task automatic expect_beat(input logic [63:0] data, input logic [1:0] kind,
                              input logic last);
      cipher_beat_type b;
      b.data = data;
      b.kind = kind;
      b.last = last;
      pending_beats.push_back(b);
   endtask

   // Advance the mirror by one accepted item and queue the beats it causes.
   task automatic cipher_step(input logic [1:0] func, input logic [63:0] word,
                              output int n);
      logic [63:0] out_word;
      n = 0;
      if (func == FUNC_NONE) return;
      // Open a message: load IV/key/nonce, 12 rounds, mix the key into lanes 3-4.
      if (!msg_open) begin
         cipher_lanes[0] = csr_shadow[CSR_INIT_VALUE];
         cipher_lanes[1] = csr_shadow[CSR_KEY_HIGH];
         cipher_lanes[2] = csr_shadow[CSR_KEY_LOW];
         cipher_lanes[3] = csr_shadow[CSR_NONCE_HIGH];
         cipher_lanes[4] = csr_shadow[CSR_NONCE_LOW];
         ascon_permute(12);
         cipher_lanes[3] = cipher_lanes[3] ^ csr_shadow[CSR_KEY_HIGH];
         cipher_lanes[4] = cipher_lanes[4] ^ csr_shadow[CSR_KEY_LOW];
         msg_open = 1'b1;
      end
      // Data word: emit word ^ lane 0, absorb the ciphertext side, 6 rounds.
      if (func == FUNC_DATA || func == FUNC_LAST) begin
         out_word = word ^ cipher_lanes[0];
         expect_beat(out_word, KIND_DATA, 1'b0);
         n++;
         cipher_lanes[0] = csr_shadow[CSR_DIRECTION][0] ? word : out_word;
         ascon_permute(6);
      end
      // Finalize with the key as it stands now and emit lanes 3 and 4.
      if (func == FUNC_LAST || func == FUNC_END) begin
         cipher_lanes[1] = cipher_lanes[1] ^ csr_shadow[CSR_KEY_HIGH];
         cipher_lanes[2] = cipher_lanes[2] ^ csr_shadow[CSR_KEY_LOW];
         ascon_permute(12);
         cipher_lanes[3] = cipher_lanes[3] ^ csr_shadow[CSR_KEY_HIGH];
         cipher_lanes[4] = cipher_lanes[4] ^ csr_shadow[CSR_KEY_LOW];
         expect_beat(cipher_lanes[3], KIND_TAG_HI, 1'b0);
         expect_beat(cipher_lanes[4], KIND_TAG_LO, 1'b1);
         n += 2;
         msg_open = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers (entered and left at a falling edge)
   // ---------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      error_count++;
      $display("MISMATCH at %0t: %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   function automatic logic [63:0] pick_word();
      case ($urandom_range(9))
         0: return 64'h0000_0000_0000_0000;
         1: return 64'hffff_ffff_ffff_ffff;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one req beat after random idle cycles, hold it until taken, then
   // predict. Valid stays high on return; the next call or a park lowers it.
   task automatic push_item(input logic [1:0] func, input logic [63:0] word,
                            output int n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cipher_step(func, word, n);
      if (func != FUNC_NONE) items_sent++;
      @(negedge clock);
   endtask

   // Drop valid, drain every expected beat, then let the sequencer finish
   // any trailing rounds before the block counts as idle.
   task automatic settle_block();
      req_tvalid = 1'b0;
      while (pending_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      csr_shadow[idx] = (idx == CSR_DIRECTION) ? {63'd0, value[0]} : value;
   endtask

   task automatic load_settings(input logic [63:0] kh, input logic [63:0] kl,
                                input logic [63:0] nh, input logic [63:0] nl,
                                input logic [63:0] iv, input logic dir);
      write_csr(CSR_KEY_HIGH, kh);
      write_csr(CSR_KEY_LOW, kl);
      write_csr(CSR_NONCE_HIGH, nh);
      write_csr(CSR_NONCE_LOW, nl);
      write_csr(CSR_INIT_VALUE, iv);
      write_csr(CSR_DIRECTION, {63'd0, dir});
      settings_count++;
   endtask

   // Mostly well-formed messages (0..5 data words closed by a last word or a
   // bare end, with a stray unused code now and then), plus a share of
   // single random items as noise.
   task automatic run_messages(input int n_items);
      int sent;
      int words;
      int n;
      logic [1:0] func;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 10) begin
            func = 2'($urandom_range(3));
            push_item(func, pick_word(), n);
            if (func != FUNC_NONE) sent++;
         end else begin
            words = $urandom_range(5);
            repeat (words) begin
               if ($urandom_range(9) == 0) push_item(FUNC_NONE, pick_word(), n);
               push_item(FUNC_DATA, pick_word(), n);
               sent++;
            end
            func = $urandom_range(1) ? FUNC_LAST : FUNC_END;
            push_item(func, pick_word(), n);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare every accepted rsp beat with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      cipher_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            flag_mismatch("beat with nothing expected", 64'd0, rsp_tdata);
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata !== want.data)
               flag_mismatch("data_out", want.data, rsp_tdata);
            if (rsp_tuser !== want.kind)
               flag_mismatch("kind", {62'd0, want.kind}, {62'd0, rsp_tuser});
            if (rsp_tlast !== want.last)
               flag_mismatch("last", {63'd0, want.last}, {63'd0, rsp_tlast});
            beats_checked++;
         end
      end
   end

   // Watchdog: count cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat accepted in %0d cycles", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int n;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 64'd0;
      req_tuser  = FUNC_DATA;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_KEY_HIGH;
      csr_wdata  = 64'd0;
      error_count    = 0;
      items_sent     = 0;
      beats_checked  = 0;
      settings_count = 1;
      hold_left      = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 14;
      recv_idle_pct  = 63;

      // Mirror the reset state: zero key and nonce, default IV, encrypt.
      csr_shadow[CSR_KEY_HIGH]   = 64'd0;
      csr_shadow[CSR_KEY_LOW]    = 64'd0;
      csr_shadow[CSR_NONCE_HIGH] = 64'd0;
      csr_shadow[CSR_NONCE_LOW]  = 64'd0;
      csr_shadow[CSR_INIT_VALUE] = IV_RESET;
      csr_shadow[CSR_DIRECTION]  = 64'd0;
      for (int i = 0; i < 5; i++) cipher_lanes[i] = 64'd0;
      msg_open = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed rows; switch every register to its top value mid-plan while
      // a message is still open, so the new key and direction hit it.
      for (int row = 0; row < PLAN_ROWS; row++) begin
         if (row == PLAN_SPLIT) begin
            settle_block();
            load_settings('1, '1, '1, '1, '1, 1'b1);
         end
         push_item(PLAN[row].func, PLAN[row].word, n);
         if (n != PLAN[row].n_beats)
            flag_mismatch("beat count of directed row", {62'd0, PLAN[row].n_beats},
                          64'(n));
      end
      settle_block();

      // Random messages, sender idling lightly and receiver heavily.
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(1)));
      run_messages(35);
      settle_block();

      // Swap the idle rates; all registers at zero, IV included, encrypt.
      send_idle_pct = 63;
      recv_idle_pct = 14;
      load_settings('0, '0, '0, '0, '0, 1'b0);
      run_messages(35);
      settle_block();

      // No idling; start with a long receiver hold-off so the result path
      // backs up and req_tready drops while items keep coming.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, IV_RESET, 1'($urandom_range(1)));
      hold_left = HOLD_CYCLES;
      run_messages(36);
      settle_block();

      $display("Covered %0d cipher items and %0d checked result beats over %0d register settings,",
               items_sent, beats_checked, settings_count);
      $display("both directions, empty and open-across-rewrite messages, and a backed-up output.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ascon_sc_pkg.sv
rtl/ascon_sc_round.sv
rtl/ascon_sc_useq.sv
rtl/ascon_aead_stream_cipher_top.sv
tb/tb_ascon_aead_stream_cipher_top.sv
